### rtl/core/pdps_pkg.sv
// ----------------------------------------------------------------------------
// pdps_pkg - shared types and constants for the PWM divider period search
// Sequencer states, divider result word and fixed search limits.
// ----------------------------------------------------------------------------
package pdps_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned DENOM_W = 49;   // target * 2^(pre+1) * scale
    localparam int unsigned DUTY_W  = 17;
    localparam int unsigned SCALE_W = 9;
    localparam int unsigned PRE_W   = 3;
    localparam int unsigned CNT_W   = 5;

    localparam logic [PRE_W-1:0]   MAX_PRESCALE   = 3'd7;
    localparam logic [SCALE_W-1:0] MAX_SCALE      = 9'd256;
    localparam logic [SCALE_W-1:0] MIN_SCALE      = 9'd1;
    localparam logic [WORD_W-1:0]  CLOCK_HZ_RESET = 32'd24000000;
    localparam logic [CNT_W-1:0]   DIV_LAST_STEP  = 5'd31;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_RANGE_ERR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_DUTY
    } pdps_state_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rem;
    } pdps_div_res_t;

endpackage

### rtl/core/pwm_divider_period_search_core.sv
// ----------------------------------------------------------------------------
// pwm_divider_period_search_core - best-fit PWM prescale / scale / period
// Sequenced search over all divider pairs with one shared divider.
// ----------------------------------------------------------------------------
// Pulse start with target_hz and duty_fraction while busy is low; the word is
// taken at that edge and busy stays high until the search ends. The result
// word appears on status/prescale/scale_code/period/duty_count for exactly one
// cycle with done high; there is no back-pressure, so capture it then. A
// normal search walks 8 prescales x 256 scales = 2048 pairs; each pair takes
// a multiply, a divider launch, the 32-step restoring divider and 2 candidate
// compares, and the duty multiply follows the last pair. A zero target or
// zero clock reports a range error in the cycle after the accept. clock_hz is
// written through cfg_wr_en/cfg_wr_data and must only change while busy is
// low and no result is pending.
// ----------------------------------------------------------------------------
module pwm_divider_period_search_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // command word
    input  logic        start,
    output logic        busy,
    input  logic [31:0] target_hz,
    input  logic [16:0] duty_fraction,
    // result word
    output logic        done,
    output logic        status,
    output logic [2:0]  prescale,
    output logic [7:0]  scale_code,
    output logic [31:0] period,
    output logic [31:0] duty_count
);

    localparam int unsigned W  = pdps_pkg::WORD_W;
    localparam int unsigned DW = pdps_pkg::DENOM_W;

    pdps_pkg::pdps_state_t state_reg, state_next;

    logic [W-1:0]                     clock_hz_reg;
    logic [W-1:0]                     target_reg,   target_next;
    logic [pdps_pkg::DUTY_W-1:0]      duty_reg,     duty_next;
    logic [pdps_pkg::PRE_W-1:0]       pre_reg,      pre_next;
    logic [pdps_pkg::SCALE_W-1:0]     sc_reg,       sc_next;
    logic [DW-1:0]                    denom_reg,    denom_next;
    logic                             found_reg,    found_next;
    logic [DW-1:0]                    best_err_reg, best_err_next;
    logic [pdps_pkg::PRE_W-1:0]       best_pre_reg, best_pre_next;
    logic [pdps_pkg::SCALE_W-1:0]     best_sc_reg,  best_sc_next;
    logic [W-1:0]                     best_per_reg, best_per_next;
    logic                             done_reg,     done_next;

    logic                             status_reg,   status_next;
    logic [pdps_pkg::PRE_W-1:0]       pre_out_reg,  pre_out_next;
    logic [7:0]                       sc_out_reg,   sc_out_next;
    logic [W-1:0]                     per_out_reg,  per_out_next;
    logic [W-1:0]                     duty_out_reg, duty_out_next;

    // shared 32x17 multiplier: target*scale during ST_MUL, period*duty in ST_DUTY
    logic [W-1:0]                     mul_a;
    logic [pdps_pkg::DUTY_W-1:0]      mul_b;
    logic [DW-1:0]                    mul_p;

    logic                             div_start;
    pdps_pkg::pdps_div_res_t          div_res;

    logic [DW-1:0]                    err_lo;
    logic [DW-1:0]                    err_hi;
    logic                             accept;

    assign accept = start && (state_reg == pdps_pkg::ST_IDLE);

    assign mul_a = (state_reg == pdps_pkg::ST_DUTY) ? best_per_reg : target_reg;
    assign mul_b = (state_reg == pdps_pkg::ST_DUTY) ? duty_reg
                 : {{(pdps_pkg::DUTY_W-pdps_pkg::SCALE_W){1'b0}}, sc_reg};
    assign mul_p = DW'(mul_a) * DW'(mul_b);

    // p = base leaves the remainder; p = base + 1 overshoots by denom - rem
    assign err_lo = {{(DW-W){1'b0}}, div_res.rem};
    assign err_hi = denom_reg - err_lo;

    assign div_start = (state_reg == pdps_pkg::ST_DIV_START);

    pdps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_hz_reg),
        .divisor  (denom_reg),
        .res      (div_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        target_next   = target_reg;
        duty_next     = duty_reg;
        pre_next      = pre_reg;
        sc_next       = sc_reg;
        denom_next    = denom_reg;
        found_next    = found_reg;
        best_err_next = best_err_reg;
        best_pre_next = best_pre_reg;
        best_sc_next  = best_sc_reg;
        best_per_next = best_per_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        pre_out_next  = pre_out_reg;
        sc_out_next   = sc_out_reg;
        per_out_next  = per_out_reg;
        duty_out_next = duty_out_reg;

        unique case (state_reg)
            pdps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    target_next = target_hz;
                    duty_next   = duty_fraction;
                    pre_next    = '0;
                    sc_next     = pdps_pkg::MIN_SCALE;
                    found_next  = 1'b0;
                    if ((target_hz == '0) || (clock_hz_reg == '0))
                    begin
                        // nothing to search: report range error at once
                        done_next     = 1'b1;
                        status_next   = pdps_pkg::STATUS_RANGE_ERR;
                        pre_out_next  = '0;
                        sc_out_next   = '0;
                        per_out_next  = '0;
                        duty_out_next = '0;
                    end
                    else
                    begin
                        state_next = pdps_pkg::ST_MUL;
                    end
                end
            end

            pdps_pkg::ST_MUL:
            begin
                // product < 2^41, shift by at most 8 keeps it in 49 bits
                denom_next = mul_p << ({1'b0, pre_reg} + 4'd1);
                state_next = pdps_pkg::ST_DIV_START;
            end

            pdps_pkg::ST_DIV_START:
            begin
                state_next = pdps_pkg::ST_DIV_WAIT;
            end

            pdps_pkg::ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = pdps_pkg::ST_CHK_LO;
                end
            end

            pdps_pkg::ST_CHK_LO:
            begin
                // floor candidate is only legal for a nonzero period
                if ((div_res.quo != '0) && (!found_reg || (err_lo < best_err_reg)))
                begin
                    found_next    = 1'b1;
                    best_err_next = err_lo;
                    best_pre_next = pre_reg;
                    best_sc_next  = sc_reg;
                    best_per_next = div_res.quo;
                end
                state_next = pdps_pkg::ST_CHK_HI;
            end

            pdps_pkg::ST_CHK_HI:
            begin
                // quotient <= clock/2, so base + 1 always fits in 32 bits
                if (!found_reg || (err_hi < best_err_reg))
                begin
                    found_next    = 1'b1;
                    best_err_next = err_hi;
                    best_pre_next = pre_reg;
                    best_sc_next  = sc_reg;
                    best_per_next = div_res.quo + 1'b1;
                end
                state_next = pdps_pkg::ST_MUL;
                if (sc_reg == pdps_pkg::MAX_SCALE)
                begin
                    sc_next = pdps_pkg::MIN_SCALE;
                    if (pre_reg == pdps_pkg::MAX_PRESCALE)
                    begin
                        state_next = pdps_pkg::ST_DUTY;
                    end
                    else
                    begin
                        pre_next = pre_reg + 1'b1;
                    end
                end
                else
                begin
                    sc_next = sc_reg + 1'b1;
                end
            end

            pdps_pkg::ST_DUTY:
            begin
                done_next  = 1'b1;
                state_next = pdps_pkg::ST_IDLE;
                if (found_reg)
                begin
                    status_next   = pdps_pkg::STATUS_OK;
                    pre_out_next  = best_pre_reg;
                    sc_out_next   = best_sc_reg[7:0];
                    per_out_next  = best_per_reg;
                    duty_out_next = mul_p[W+15:16];
                end
                else
                begin
                    status_next   = pdps_pkg::STATUS_RANGE_ERR;
                    pre_out_next  = '0;
                    sc_out_next   = '0;
                    per_out_next  = '0;
                    duty_out_next = '0;
                end
            end

            default:
            begin
                state_next = pdps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pdps_pkg::ST_IDLE;
            clock_hz_reg <= pdps_pkg::CLOCK_HZ_RESET;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
            pre_reg      <= '0;
            sc_reg       <= pdps_pkg::MIN_SCALE;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            done_reg  <= done_next;
            pre_reg   <= pre_next;
            sc_reg    <= sc_next;
            if (cfg_wr_en)
            begin
                clock_hz_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        duty_reg     <= duty_next;
        denom_reg    <= denom_next;
        best_err_reg <= best_err_next;
        best_pre_reg <= best_pre_next;
        best_sc_reg  <= best_sc_next;
        best_per_reg <= best_per_next;
        status_reg   <= status_next;
        pre_out_reg  <= pre_out_next;
        sc_out_reg   <= sc_out_next;
        per_out_reg  <= per_out_next;
        duty_out_reg <= duty_out_next;
    end

    assign busy       = (state_reg != pdps_pkg::ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign prescale   = pre_out_reg;
    assign scale_code = sc_out_reg;
    assign period     = per_out_reg;
    assign duty_count = duty_out_reg;

    // a result word only follows the duty step or an immediate range error
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == pdps_pkg::ST_DUTY) || $past(accept))
        else $error("done strobe without a finished search");

    // restoring divider must leave a remainder below the divisor
    a_rem_below_denom: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdps_pkg::ST_CHK_LO) |-> (err_lo < denom_reg))
        else $error("divider remainder not below denominator");

    // divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == pdps_pkg::ST_DIV_WAIT))
        else $error("divider done outside wait state");

endmodule

### rtl/core/pdps_div.sv
// ----------------------------------------------------------------------------
// pdps_div - iterative restoring divider
// 32-bit dividend by 49-bit divisor, one quotient bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
module pdps_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pdps_pkg::WORD_W-1:0]       dividend,
    input  logic [pdps_pkg::DENOM_W-1:0]      divisor,
    output pdps_pkg::pdps_div_res_t           res
);

    logic                          run_reg,  run_next;
    logic                          done_reg, done_next;
    logic [pdps_pkg::CNT_W-1:0]    cnt_reg,  cnt_next;
    logic [pdps_pkg::WORD_W-1:0]   rem_reg,  rem_next;
    logic [pdps_pkg::WORD_W-1:0]   quo_reg,  quo_next;

    logic [pdps_pkg::WORD_W:0]     trial;
    logic [pdps_pkg::WORD_W:0]     diff;
    logic                          fits;

    // partial remainder never exceeds the dividend, so it stays 32 bits
    assign trial = {rem_reg, quo_reg[pdps_pkg::WORD_W-1]};
    assign fits  = {{(pdps_pkg::DENOM_W-pdps_pkg::WORD_W-1){1'b0}}, trial} >= divisor;
    assign diff  = trial - divisor[pdps_pkg::WORD_W:0];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[pdps_pkg::WORD_W-1:0]
                            : trial[pdps_pkg::WORD_W-1:0];
            quo_next = {quo_reg[pdps_pkg::WORD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pdps_pkg::DIV_LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

### sim/pwm_divider_period_search_checker.sv
// ----------------------------------------------------------------------------
// pwm_divider_period_search_checker - result predictor and scoreboard
// Watches the config, command and result ports, predicts the best-fit divider
// for each accepted command word and compares every result word against it.
// ----------------------------------------------------------------------------
module pwm_divider_period_search_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] target_hz,
    input  logic [16:0] duty_fraction,
    input  logic        done,
    input  logic        status,
    input  logic [2:0]  prescale,
    input  logic [7:0]  scale_code,
    input  logic [31:0] period,
    input  logic [31:0] duty_count,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        status;
        logic [2:0]  prescale;
        logic [7:0]  scale_code;
        logic [31:0] period;
        logic [31:0] duty_count;
    } divider_fit_t;

    logic [31:0]  clock_hz;
    divider_fit_t fit_q[$];
    divider_fit_t want;
    int           mismatches = 0;
    int           waiting    = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    // Exhaustive walk over prescale/scale; strict '<' keeps the earliest tie.
    function automatic divider_fit_t best_divider_fit(
        input logic [31:0] clk_hz,
        input logic [31:0] tgt,
        input logic [16:0] duty
    );
        divider_fit_t fit;
        logic [63:0]  denom;
        logic [63:0]  base;
        logic [63:0]  per;
        logic [63:0]  prod;
        logic [63:0]  err;
        logic [63:0]  best_err;
        logic [63:0]  best_per;
        int           best_pre;
        int           best_sc;
        bit           found;
        fit        = '0;
        fit.status = pdps_pkg::STATUS_RANGE_ERR;
        found      = 1'b0;
        best_err   = '0;
        best_per   = '0;
        best_pre   = 0;
        best_sc    = 0;
        if (tgt == '0 || clk_hz == '0)
            return fit;
        for (int pre = 0; pre <= int'(pdps_pkg::MAX_PRESCALE); pre++) begin
            for (int sc = int'(pdps_pkg::MIN_SCALE); sc <= int'(pdps_pkg::MAX_SCALE);
                 sc++) begin
                denom = 64'(tgt) * (64'd1 << (pre + 1)) * 64'(sc);
                base  = 64'(clk_hz) / denom;
                for (int adj = 0; adj <= 1; adj++) begin
                    per = base + 64'(adj);
                    if (per < 64'd1 || per > 64'hFFFF_FFFF)
                        continue;
                    prod = denom * per;
                    err  = (64'(clk_hz) > prod) ? 64'(clk_hz) - prod : prod - 64'(clk_hz);
                    if (!found || err < best_err) begin
                        found    = 1'b1;
                        best_err = err;
                        best_pre = pre;
                        best_sc  = sc;
                        best_per = per;
                    end
                end
            end
        end
        if (!found)
            return fit;
        fit.status     = pdps_pkg::STATUS_OK;
        fit.prescale   = best_pre[2:0];
        fit.scale_code = best_sc[7:0];
        fit.period     = best_per[31:0];
        prod           = (best_per * 64'(duty)) >> 16;
        fit.duty_count = prod[31:0];
        return fit;
    endfunction

    // Result first, then command, then register write: a command taken on
    // the same edge as a write still sees the old clock.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clock_hz = pdps_pkg::CLOCK_HZ_RESET;
            fit_q.delete();
            waiting  = 0;
        end
        else begin
            if (done) begin
                if (fit_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end
                else begin
                    want = fit_q.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                    if (prescale !== want.prescale) begin
                        $error("prescale: expected %0d, actual %0d", want.prescale, prescale);
                        mismatches++;
                    end
                    if (scale_code !== want.scale_code) begin
                        $error("scale_code: expected %0d, actual %0d",
                               want.scale_code, scale_code);
                        mismatches++;
                    end
                    if (period !== want.period) begin
                        $error("period: expected %0d, actual %0d", want.period, period);
                        mismatches++;
                    end
                    if (duty_count !== want.duty_count) begin
                        $error("duty_count: expected %0d, actual %0d",
                               want.duty_count, duty_count);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                fit_q.push_back(best_divider_fit(clock_hz, target_hz, duty_fraction));
            if (cfg_wr_en)
                clock_hz = cfg_wr_data;
            waiting = fit_q.size();
        end
    end

endmodule

### sim/pwm_divider_period_search_core_tb.sv
// ----------------------------------------------------------------------------
// pwm_divider_period_search_core_tb - top of the divider search testbench
// Drives command words and clock_hz writes into the core; the checker beside
// it predicts each result word and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module pwm_divider_period_search_core_tb;

    // Covers ~125 words at most, each running a full search, and leaves
    // roughly four times the slowest legal run.
    localparam longint CYCLE_LIMIT = 40_000_000;
    // Quiet time after the last result, well past the range-error path.
    localparam int     TAIL_CYCLES = 64;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        start;
    logic        busy;
    logic [31:0] target_hz;
    logic [16:0] duty_fraction;
    logic        done;
    logic        status;
    logic [2:0]  prescale;
    logic [7:0]  scale_code;
    logic [31:0] period;
    logic [31:0] duty_count;

    int          fail_count;
    int          pending;
    longint      cycle_count = 0;
    // When set, the sender never inserts idle cycles (the no-idle stretch).
    bit          steady      = 1'b0;

    pwm_divider_period_search_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .start         (start),
        .busy          (busy),
        .target_hz     (target_hz),
        .duty_fraction (duty_fraction),
        .done          (done),
        .status        (status),
        .prescale      (prescale),
        .scale_code    (scale_code),
        .period        (period),
        .duty_count    (duty_count)
    );

    pwm_divider_period_search_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .start         (start),
        .busy          (busy),
        .target_hz     (target_hz),
        .duty_fraction (duty_fraction),
        .done          (done),
        .status        (status),
        .prescale      (prescale),
        .scale_code    (scale_code),
        .period        (period),
        .duty_count    (duty_count),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: a hung search or lost result word ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pwm_divider_period_search_core: mismatch");
            $finish;
        end
    end

    // Mostly realistic PWM rates; a slice of full-range values exercises the
    // high bits, and zero targets hit the range-error path.
    function automatic logic [31:0] random_target();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom;
            2:       return 32'($urandom_range(1, 16));
            default: return 32'($urandom_range(1, 200_000));
        endcase
    endfunction

    // Duty mostly within 0..100 percent; some words go above full scale,
    // which the core uses as given.
    function automatic logic [16:0] random_duty();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 17'd65536;
            2:       return 17'($urandom_range(0, 17'h1FFFF));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Present one command word and hold it until taken. busy only moves at
    // rising edges, so its value at a falling edge is what the next rising
    // edge sees. start is left high on return, so back-to-back words drop it only
    // for an inserted idle gap; anything else that follows lowers it first.
    task automatic send_word(input logic [31:0] tgt, input logic [16:0] duty);
        bit taken;
        if (!steady && $urandom_range(99) < 8) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start         = 1'b1;
        target_hz     = tgt;
        duty_fraction = duty;
        do begin
            taken = !busy;
            @(negedge clk);
        end while (!taken);
    endtask

    // Sender holds off until every predicted word has come back.
    task automatic drain_results();
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    // clock_hz may only change with the core idle and nothing outstanding.
    task automatic set_clock(input logic [31:0] hz);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = hz;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        start         = 1'b0;
        target_hz     = '0;
        duty_fraction = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words at the reset clock (24 MHz).
        send_word(32'd1, 17'd0);                // slowest target, huge period
        send_word(32'hFFFF_FFFF, 17'd65536);    // target far above clock
        send_word(32'd0, 17'd32768);            // zero target: range error
        send_word(32'd24_000_000, 17'd65535);   // target equals clock
        send_word(32'd12_000_000, 17'd1);
        send_word(32'd46_875, 17'd32768);       // many exact fits, earliest wins
        send_word(32'd1000, 17'h1FFFF);         // duty above full scale
        send_word(32'd3, 17'd21845);            // exact fit at the first pair
        send_word(32'd7, 17'd65536);
        send_word(32'd25_000, 17'd16384);
        send_word(32'd1_000_000, 17'h10001);
        drain_results();

        // Zero clock: every word is a range error.
        set_clock(32'd0);
        send_word(32'd5, 17'd100);
        send_word(32'hFFFF_FFFF, 17'h1FFFF);

        // Smallest nonzero clock.
        set_clock(32'd1);
        send_word(32'd1, 17'd65536);
        send_word(32'hFFFF_FFFF, 17'd32768);

        // Largest clock: biggest periods and duty products.
        set_clock(32'hFFFF_FFFF);
        send_word(32'd1, 17'h1FFFF);
        send_word(32'd1, 17'd65536);
        send_word(32'h8000_0000, 17'd12345);
        send_word(32'hFFFF_FFFF, 17'd0);

        // Random phases, each under its own clock setting; the middle one
        // runs without the sender's random idle cycles.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       set_clock(32'd100_000_000);
                1:       set_clock($urandom);
                2:       set_clock(32'd24_000_000);
                3:       set_clock(32'($urandom_range(1, 5000)));
                default: set_clock(32'hFFFF_FFFF);
            endcase
            steady = (ph == 2);
            for (int n = 0; n < 20; n++) begin
                if (n == 10 || $urandom_range(99) < 3)
                    drain_results();
                send_word(random_target(), random_duty());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("pwm_divider_period_search_core: match");
        else
            $display("pwm_divider_period_search_core: mismatch");
        $finish;
    end

endmodule
